// File: rtl/ddt_pkg.sv
package ddt_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int BLOCK_DEPTH = 16;

  localparam int POS_W = 16;
  localparam int PIX_W = 12;
  localparam int LIM_W = 15;
  localparam int TRK_W = 5;
  localparam int STATUS_W = 3;
  localparam int IDX_OUT_W = 4;
  localparam int CNT_OUT_W = 5;

  localparam int CFG_IDX_W = 4;
  localparam int CFG_DATA_W = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MATCH_RADIUS  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_X_LIMIT       = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_LIMIT       = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TRACKED_ENTRY = 4'd3;

  localparam logic [LIM_W-1:0] RST_MATCH_RADIUS  = 15'd1843;
  localparam logic [LIM_W-1:0] RST_X_LIMIT       = 15'd22528;
  localparam logic [LIM_W-1:0] RST_Y_LIMIT       = 15'd10240;
  localparam logic [TRK_W-1:0] RST_TRACKED_ENTRY = 5'd16;

  typedef enum logic [STATUS_W-1:0] {
    ST_BOUNDS  = 3'd0,
    ST_BLACK   = 3'd1,
    ST_MATCH   = 3'd2,
    ST_ADDED   = 3'd3,
    ST_FULL    = 3'd4,
    ST_BSTORED = 3'd5,
    ST_BFULL   = 3'd6
  } status_t;

endpackage

// File: rtl/ddt_if.sv
interface ddt_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 func;
  logic signed [ddt_pkg::POS_W-1:0]     pos_x;
  logic signed [ddt_pkg::POS_W-1:0]     pos_y;
  logic        [ddt_pkg::PIX_W-1:0]     pix_x;
  logic        [ddt_pkg::PIX_W-1:0]     pix_y;

  modport source (output valid, func, pos_x, pos_y, pix_x, pix_y, input ready);
  modport sink (input valid, func, pos_x, pos_y, pix_x, pix_y, output ready);
endinterface

interface ddt_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [ddt_pkg::STATUS_W-1:0]         status;
  logic [ddt_pkg::IDX_OUT_W-1:0]        entry_index;
  logic                                 tracked_hit;
  logic [ddt_pkg::CNT_OUT_W-1:0]        entry_count;

  modport source (output valid, status, entry_index, tracked_hit, entry_count, input ready);
  modport sink (input valid, status, entry_index, tracked_hit, entry_count, output ready);
endinterface

interface ddt_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [ddt_pkg::CFG_IDX_W-1:0]        index;
  logic [ddt_pkg::CFG_DATA_W-1:0]       data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/detection_dedup_table_core.sv
// channel  | modport | word                                   | accepted when
// det      | sink    | func, pos_x, pos_y, pix_x, pix_y       | det.valid && det.ready
// res      | source  | status, entry_index, tracked_hit,      | res.valid && res.ready
//          |         | entry_count                            |
// cfg      | sink    | index, data (always ready)             | cfg.valid && cfg.ready
//
// one item at a time; det.ready is high only while the sequencer is idle
// loads and out-of-bounds detections pass S_CHECK and then S_DONE, which raises res.valid
// a detection that reaches the walks passes S_CHECK, S_BWALK, then S_OWALK unless the
// blacklist matched, then S_DONE; each walk takes one entry a cycle through the
// single read port and the shared distance pipe; S_DONE returns to S_IDLE as it raises res.valid
// rst clears both counts and resets the registers; the entry memories need no clearing
// a result waiting on res.ready does not block the next det word

module detection_dedup_table_core #(
  parameter int TABLE_DEPTH = ddt_pkg::TABLE_DEPTH,
  parameter int BLOCK_DEPTH = ddt_pkg::BLOCK_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  ddt_in_if.sink           det,
  ddt_out_if.source        res,
  ddt_cfg_if.sink          cfg
);

  localparam int TW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int BW   = (BLOCK_DEPTH > 1) ? $clog2(BLOCK_DEPTH) : 1;
  localparam int IW   = (TW > BW) ? TW : BW;
  localparam int MAXD = (TABLE_DEPTH > BLOCK_DEPTH) ? TABLE_DEPTH : BLOCK_DEPTH;
  localparam int NW   = $clog2(MAXD + 1);
  localparam int TCW  = $clog2(TABLE_DEPTH + 1);
  localparam int BCW  = $clog2(BLOCK_DEPTH + 1);
  localparam int PW   = ddt_pkg::POS_W;
  localparam int XW   = ddt_pkg::PIX_W;
  localparam int LW   = ddt_pkg::LIM_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_BWALK,
    S_OWALK,
    S_DONE
  } state_t;

  state_t state;

  // registers
  logic [LW-1:0]                   match_radius;
  logic [LW-1:0]                   x_limit;
  logic [LW-1:0]                   y_limit;
  logic [ddt_pkg::TRK_W-1:0]       tracked_entry;

  logic [TCW-1:0]                  obj_count;
  logic [BCW-1:0]                  block_count;

  // latched item
  logic                            item_func;
  logic signed [PW-1:0]            item_x;
  logic signed [PW-1:0]            item_y;
  logic [XW-1:0]                   item_pix_x;
  logic [XW-1:0]                   item_pix_y;

  // entry memories
  logic [2*PW-1:0]                 obj_pos [TABLE_DEPTH];
  logic [2*XW-1:0]                 obj_pix [TABLE_DEPTH];
  logic [2*PW-1:0]                 blk_pos [BLOCK_DEPTH];
  logic [2*PW-1:0]                 obj_rd;
  logic [2*PW-1:0]                 blk_rd;

  // walk sequencer and distance pipe
  logic [NW-1:0]                   iss;
  logic [NW-1:0]                   limit;
  logic                            rd_en;
  logic                            v1, v2, v3;
  logic [IW-1:0]                   i1, i2, i3;
  logic                            found;
  logic [IW-1:0]                   fidx;
  logic                            walk_end;
  logic [2*LW-1:0]                 r2;
  logic [PW-1:0]                   ad_x, ad_y;
  logic [2*PW-1:0]                 sq_x, sq_y;
  logic                            near;

  logic signed [PW-1:0]            rd_x, rd_y;
  logic signed [PW:0]              dx, dy;
  logic [PW-1:0]                   abs_x, abs_y;
  logic                            out_bounds;

  // pending result
  ddt_pkg::status_t                res_status;
  logic [ddt_pkg::IDX_OUT_W-1:0]   res_idx;
  logic                            res_hit;

  logic                            blk_we;
  logic                            obj_done;
  logic                            obj_space;
  logic                            obj_we;
  logic                            pix_we;
  logic [TW-1:0]                   pix_waddr;

  assign det.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;

  assign abs_x = item_x[PW-1] ? PW'(-item_x) : PW'(item_x);
  assign abs_y = item_y[PW-1] ? PW'(-item_y) : PW'(item_y);
  assign out_bounds = (abs_x >= {1'b0, x_limit}) || (abs_y >= {1'b0, y_limit});

  assign limit = (state == S_OWALK) ? NW'(obj_count) : NW'(block_count);
  assign rd_en = ((state == S_BWALK) || (state == S_OWALK)) && !found && (iss < limit);
  assign walk_end = found || ((iss == limit) && !v1 && !v2 && !v3);

  assign obj_space = (obj_count < TCW'(TABLE_DEPTH));
  assign blk_we    = (state == S_CHECK) && item_func && (block_count < BCW'(BLOCK_DEPTH));
  assign obj_done  = (state == S_OWALK) && walk_end;
  assign obj_we    = obj_done && !found && obj_space;
  assign pix_we    = obj_done && (found || obj_space);
  assign pix_waddr = found ? fidx[TW-1:0] : obj_count[TW-1:0];

  // shared distance pipe: read, difference, square, compare
  assign rd_x = (state == S_OWALK) ? obj_rd[2*PW-1:PW] : blk_rd[2*PW-1:PW];
  assign rd_y = (state == S_OWALK) ? obj_rd[PW-1:0]    : blk_rd[PW-1:0];
  assign dx   = {item_x[PW-1], item_x} - {rd_x[PW-1], rd_x};
  assign dy   = {item_y[PW-1], item_y} - {rd_y[PW-1], rd_y};
  assign near = (({1'b0, sq_x} + {1'b0, sq_y}) < {3'b000, r2});

  always_ff @(posedge clk) begin
    if (rd_en) begin
      obj_rd <= obj_pos[iss[TW-1:0]];
      blk_rd <= blk_pos[iss[BW-1:0]];
    end
    if (obj_we) begin
      obj_pos[obj_count[TW-1:0]] <= {item_x, item_y};
    end
    if (pix_we) begin
      obj_pix[pix_waddr] <= {item_pix_x, item_pix_y};
    end
    if (blk_we) begin
      blk_pos[block_count[BW-1:0]] <= {item_x, item_y};
    end
  end

  always_ff @(posedge clk) begin
    ad_x <= dx[PW] ? PW'(-dx) : dx[PW-1:0];
    ad_y <= dy[PW] ? PW'(-dy) : dy[PW-1:0];
    sq_x <= (2*PW)'(ad_x) * (2*PW)'(ad_x);
    sq_y <= (2*PW)'(ad_y) * (2*PW)'(ad_y);
    i2   <= i1;
    i3   <= i2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      match_radius  <= ddt_pkg::RST_MATCH_RADIUS;
      x_limit       <= ddt_pkg::RST_X_LIMIT;
      y_limit       <= ddt_pkg::RST_Y_LIMIT;
      tracked_entry <= ddt_pkg::RST_TRACKED_ENTRY;
      obj_count     <= '0;
      block_count   <= '0;
      iss           <= '0;
      v1            <= 1'b0;
      v2            <= 1'b0;
      v3            <= 1'b0;
      found         <= 1'b0;
      res.valid     <= 1'b0;
    end else begin
      if (cfg.valid) begin
        case (cfg.index)
          ddt_pkg::CFG_MATCH_RADIUS:  match_radius  <= cfg.data[LW-1:0];
          ddt_pkg::CFG_X_LIMIT:       x_limit       <= cfg.data[LW-1:0];
          ddt_pkg::CFG_Y_LIMIT:       y_limit       <= cfg.data[LW-1:0];
          ddt_pkg::CFG_TRACKED_ENTRY: tracked_entry <= cfg.data[ddt_pkg::TRK_W-1:0];
          default: ;
        endcase
      end

      if (res.valid && res.ready && (state != S_DONE)) begin
        res.valid <= 1'b0;
      end

      v1 <= 1'b0;
      v2 <= v1;
      v3 <= v2;
      if (rd_en) begin
        v1  <= 1'b1;
        i1  <= IW'(iss);
        iss <= iss + 1'b1;
      end
      // only the lowest matching index counts
      if (v3 && near && !found) begin
        found <= 1'b1;
        fidx  <= i3;
      end

      case (state)
        S_IDLE: begin
          if (det.valid) begin
            item_func  <= det.func;
            item_x     <= det.pos_x;
            item_y     <= det.pos_y;
            item_pix_x <= det.pix_x;
            item_pix_y <= det.pix_y;
            state      <= S_CHECK;
          end
        end
        S_CHECK: begin
          r2      <= (2*LW)'(match_radius) * (2*LW)'(match_radius);
          iss     <= '0;
          found   <= 1'b0;
          res_hit <= 1'b0;
          res_idx <= '0;
          if (item_func) begin
            if (blk_we) begin
              res_status  <= ddt_pkg::ST_BSTORED;
              res_idx     <= ddt_pkg::IDX_OUT_W'(block_count);
              block_count <= block_count + 1'b1;
            end else begin
              res_status <= ddt_pkg::ST_BFULL;
            end
            state <= S_DONE;
          end else if (out_bounds) begin
            res_status <= ddt_pkg::ST_BOUNDS;
            state      <= S_DONE;
          end else begin
            state <= S_BWALK;
          end
        end
        S_BWALK: begin
          if (walk_end) begin
            if (found) begin
              res_status <= ddt_pkg::ST_BLACK;
              state      <= S_DONE;
            end else begin
              iss   <= '0;
              found <= 1'b0;
              v1    <= 1'b0;
              v2    <= 1'b0;
              v3    <= 1'b0;
              state <= S_OWALK;
            end
          end
        end
        S_OWALK: begin
          if (walk_end) begin
            if (found) begin
              res_status <= ddt_pkg::ST_MATCH;
              res_idx    <= ddt_pkg::IDX_OUT_W'(fidx);
              res_hit    <= (32'(fidx) == 32'(tracked_entry));
            end else if (obj_space) begin
              res_status <= ddt_pkg::ST_ADDED;
              res_idx    <= ddt_pkg::IDX_OUT_W'(obj_count);
              obj_count  <= obj_count + 1'b1;
            end else begin
              res_status <= ddt_pkg::ST_FULL;
            end
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!res.valid || res.ready) begin
            res.valid       <= 1'b1;
            res.status      <= res_status;
            res.entry_index <= res_idx;
            res.tracked_hit <= res_hit;
            res.entry_count <= ddt_pkg::CNT_OUT_W'(obj_count);
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/ddt_checker.sv
module ddt_checker #(
  parameter int TABLE_DEPTH = ddt_pkg::TABLE_DEPTH
) (
  input logic                             clk,
  input logic                             rst,
  input logic                             det_valid,
  input logic                             det_ready,
  input logic                             res_valid,
  input logic                             res_ready,
  input logic [ddt_pkg::STATUS_W-1:0]     res_status,
  input logic [ddt_pkg::IDX_OUT_W-1:0]    res_entry_index,
  input logic                             res_tracked_hit,
  input logic [ddt_pkg::CNT_OUT_W-1:0]    res_entry_count
);

  // a held result word keeps its status and entry count
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_status) && $stable(res_entry_count))
    else $error("result word changed while stalled");

  // one item at a time: ready drops right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    det_valid && det_ready |=> !det_ready)
    else $error("det accepted while busy");

  a_hit_only_match: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_tracked_hit |-> res_status == ddt_pkg::ST_MATCH)
    else $error("tracked hit without a match");

  a_idx_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_status == ddt_pkg::ST_BOUNDS || res_status == ddt_pkg::ST_BLACK ||
                  res_status == ddt_pkg::ST_FULL || res_status == ddt_pkg::ST_BFULL)
    |-> res_entry_index == '0)
    else $error("entry index set on a result with no entry");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> 32'(res_entry_count) <= TABLE_DEPTH)
    else $error("entry count beyond table depth");

endmodule

bind detection_dedup_table_core ddt_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_ddt_checker (
  .clk             (clk),
  .rst             (rst),
  .det_valid       (det.valid),
  .det_ready       (det.ready),
  .res_valid       (res.valid),
  .res_ready       (res.ready),
  .res_status      (res.status),
  .res_entry_index (res.entry_index),
  .res_tracked_hit (res.tracked_hit),
  .res_entry_count (res.entry_count)
);

// File: test/dedup_table_checker.sv
module dedup_table_checker (
  input  logic clk,
  input  logic rst,
  ddt_in_if    det,
  ddt_out_if   res,
  ddt_cfg_if   cfg,
  output int   errors,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import ddt_pkg::*;

  typedef struct {
    status_t                status;
    logic [IDX_OUT_W-1:0]   entry_index;
    logic                   tracked_hit;
    logic [CNT_OUT_W-1:0]   entry_count;
  } dedup_word_t;

  logic [LIM_W-1:0] radius;
  logic [LIM_W-1:0] x_lim;
  logic [LIM_W-1:0] y_lim;
  logic [TRK_W-1:0] tracked;

  logic signed [POS_W-1:0] obj_x [TABLE_DEPTH];
  logic signed [POS_W-1:0] obj_y [TABLE_DEPTH];
  logic        [PIX_W-1:0] obj_px [TABLE_DEPTH];
  logic        [PIX_W-1:0] obj_py [TABLE_DEPTH];
  int                      obj_n;
  logic signed [POS_W-1:0] blk_x [BLOCK_DEPTH];
  logic signed [POS_W-1:0] blk_y [BLOCK_DEPTH];
  int                      blk_n;

  dedup_word_t outcomes_due[$];
  dedup_word_t due;

  initial begin
    errors = 0;
    pending = 0;
  end

  function automatic int magnitude(input logic signed [POS_W-1:0] v);
    return (v < 0) ? -int'(v) : int'(v);
  endfunction

  // strict test on squared distance, exact in 64 bits
  function automatic bit is_near(input logic signed [POS_W-1:0] ax, ay, bx, by);
    longint dx;
    longint dy;
    dx = longint'(ax) - longint'(bx);
    dy = longint'(ay) - longint'(by);
    return dx * dx + dy * dy < longint'(radius) * longint'(radius);
  endfunction

  function automatic dedup_word_t dedup_outcome(input logic f,
                                                input logic signed [POS_W-1:0] x, y,
                                                input logic [PIX_W-1:0] px, py);
    dedup_word_t w;
    bit black;
    bit found;
    w.status = ST_BOUNDS;
    w.entry_index = '0;
    w.tracked_hit = 1'b0;
    black = 1'b0;
    found = 1'b0;
    if (f) begin
      if (blk_n < BLOCK_DEPTH) begin
        blk_x[blk_n] = x;
        blk_y[blk_n] = y;
        w.entry_index = IDX_OUT_W'(blk_n);
        blk_n++;
        w.status = ST_BSTORED;
      end else begin
        w.status = ST_BFULL;
      end
    end else if (magnitude(x) >= int'(x_lim) || magnitude(y) >= int'(y_lim)) begin
      w.status = ST_BOUNDS;
    end else begin
      for (int i = 0; i < blk_n && !black; i++)
        black = is_near(x, y, blk_x[i], blk_y[i]);
      if (black) begin
        w.status = ST_BLACK;
      end else begin
        // lowest index wins when several entries are close
        for (int i = 0; i < obj_n && !found; i++) begin
          if (is_near(x, y, obj_x[i], obj_y[i])) begin
            obj_px[i] = px;
            obj_py[i] = py;
            w.entry_index = IDX_OUT_W'(i);
            w.tracked_hit = (i == int'(tracked));
            found = 1'b1;
          end
        end
        if (found) begin
          w.status = ST_MATCH;
        end else if (obj_n < TABLE_DEPTH) begin
          obj_x[obj_n] = x;
          obj_y[obj_n] = y;
          obj_px[obj_n] = px;
          obj_py[obj_n] = py;
          w.entry_index = IDX_OUT_W'(obj_n);
          obj_n++;
          w.status = ST_ADDED;
        end else begin
          w.status = ST_FULL;
        end
      end
    end
    w.entry_count = CNT_OUT_W'(obj_n);
    return w;
  endfunction

  function automatic void compare_field(input string name, input int unsigned want,
                                        input logic [7:0] got);
    if (got !== 8'(want)) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      radius = RST_MATCH_RADIUS;
      x_lim = RST_X_LIMIT;
      y_lim = RST_Y_LIMIT;
      tracked = RST_TRACKED_ENTRY;
      obj_n = 0;
      blk_n = 0;
      outcomes_due.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_MATCH_RADIUS:  radius = cfg.data[LIM_W-1:0];
          CFG_X_LIMIT:       x_lim = cfg.data[LIM_W-1:0];
          CFG_Y_LIMIT:       y_lim = cfg.data[LIM_W-1:0];
          CFG_TRACKED_ENTRY: tracked = cfg.data[TRK_W-1:0];
          default: ;
        endcase
      end
      if (det.valid && det.ready)
        outcomes_due.push_back(dedup_outcome(det.func, det.pos_x, det.pos_y,
                                             det.pix_x, det.pix_y));
      if (res.valid && res.ready) begin
        if (outcomes_due.size() == 0) begin
          $error("result word with nothing expected: status %0d index %0d",
                 res.status, res.entry_index);
          errors++;
        end else begin
          due = outcomes_due.pop_front();
          compare_field("status", due.status, 8'(res.status));
          compare_field("entry_index", due.entry_index, 8'(res.entry_index));
          compare_field("tracked_hit", due.tracked_hit, 8'(res.tracked_hit));
          compare_field("entry_count", due.entry_count, 8'(res.entry_count));
        end
      end
    end
    pending = outcomes_due.size();
  end

endmodule

// File: test/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ddt_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SEEN_MAX = 20;
  // no register sits at this index, the write must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 4'd9;

  logic clk;
  logic rst;
  int   errors;
  int   pending;
  int   cycles = 0;

  ddt_in_if  det ();
  ddt_out_if res ();
  ddt_cfg_if cfg ();

  // live settings, only used to aim positions
  int cur_radius = RST_MATCH_RADIUS;
  int cur_xlim = RST_X_LIMIT;
  int cur_ylim = RST_Y_LIMIT;

  int obj_seen_x[$];
  int obj_seen_y[$];
  int blk_seen_x[$];
  int blk_seen_y[$];

  bit det_calm = 1'b0;
  bit res_calm = 1'b0;

  detection_dedup_table_core i_dut (
    .clk (clk),
    .rst (rst),
    .det (det),
    .res (res),
    .cfg (cfg)
  );

  dedup_table_checker i_chk (
    .clk     (clk),
    .rst     (rst),
    .det     (det),
    .res     (res),
    .cfg     (cfg),
    .errors  (errors),
    .pending (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // result side: random stalls per word, with calm stretches
  initial begin
    int stall;
    res.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if ($urandom_range(0, 39) == 0) res_calm = !res_calm;
      stall = res_calm ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        res.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res.ready <= 1'b1;
      do @(posedge clk); while (!(res.valid && res.ready));
    end
  end

  function automatic logic signed [POS_W-1:0] any_pos();
    return POS_W'($urandom);
  endfunction

  function automatic logic [PIX_W-1:0] any_pix();
    return PIX_W'($urandom);
  endfunction

  function automatic logic signed [POS_W-1:0] pos_inside(input int lim);
    if (lim == 0) return any_pos();
    return POS_W'(int'($urandom_range(0, 2 * lim - 2)) - (lim - 1));
  endfunction

  function automatic logic signed [POS_W-1:0] pos_near(input int base);
    int r;
    r = (cur_radius > 0) ? cur_radius : 8;
    return POS_W'(base + int'($urandom_range(0, 2 * r)) - r);
  endfunction

  // valid stays up across back-to-back words when no gap is drawn
  task automatic send_item(input logic f, input logic signed [POS_W-1:0] x, y,
                           input logic [PIX_W-1:0] px, py);
    int gap;
    int ax;
    int ay;
    if ($urandom_range(0, 39) == 0) det_calm = !det_calm;
    gap = det_calm ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      det.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    det.valid <= 1'b1;
    det.func  <= f;
    det.pos_x <= x;
    det.pos_y <= y;
    det.pix_x <= px;
    det.pix_y <= py;
    do @(posedge clk); while (!(det.valid && det.ready));
    ax = (x < 0) ? -int'(x) : int'(x);
    ay = (y < 0) ? -int'(y) : int'(y);
    if (f && blk_seen_x.size() < SEEN_MAX) begin
      blk_seen_x.push_back(int'(x));
      blk_seen_y.push_back(int'(y));
    end else if (!f && ax < cur_xlim && ay < cur_ylim && obj_seen_x.size() < SEEN_MAX) begin
      obj_seen_x.push_back(int'(x));
      obj_seen_y.push_back(int'(y));
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= CFG_DATA_W'(value);
    do @(posedge clk); while (!(cfg.valid && cfg.ready));
  endtask

  task automatic wait_quiet;
    det.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  // upper data bits beyond each register's width ride along at random
  task automatic apply_settings(input int r, xl, yl, trk);
    wait_quiet();
    write_reg(CFG_MATCH_RADIUS, r + ($urandom_range(0, 1) << LIM_W));
    write_reg(CFG_X_LIMIT, xl + ($urandom_range(0, 1) << LIM_W));
    write_reg(CFG_Y_LIMIT, yl + ($urandom_range(0, 1) << LIM_W));
    write_reg(CFG_TRACKED_ENTRY, trk + ($urandom_range(0, 2047) << TRK_W));
    write_reg(CFG_UNMAPPED, $urandom);
    cfg.valid <= 1'b0;
    cur_radius = r;
    cur_xlim = xl;
    cur_ylim = yl;
  endtask

  task automatic random_item;
    int kind;
    int k;
    kind = $urandom_range(0, 99);
    if (kind < 3) begin
      if ($urandom_range(0, 1))
        send_item(1'b1, any_pos(), any_pos(), any_pix(), any_pix());
      else
        send_item(1'b1, pos_inside(cur_xlim), pos_inside(cur_ylim), any_pix(), any_pix());
    end else if (kind < 13) begin
      send_item(1'b0, any_pos(), any_pos(), any_pix(), any_pix());
    end else if (kind < 63 && obj_seen_x.size() > 0) begin
      k = $urandom_range(0, obj_seen_x.size() - 1);
      send_item(1'b0, pos_near(obj_seen_x[k]), pos_near(obj_seen_y[k]), any_pix(), any_pix());
    end else if (kind < 70 && blk_seen_x.size() > 0) begin
      k = $urandom_range(0, blk_seen_x.size() - 1);
      send_item(1'b0, pos_near(blk_seen_x[k]), pos_near(blk_seen_y[k]), any_pix(), any_pix());
    end else begin
      send_item(1'b0, pos_inside(cur_xlim), pos_inside(cur_ylim), any_pix(), any_pix());
    end
  endtask

  initial begin
    rst       <= 1'b1;
    det.valid <= 1'b0;
    det.func  <= 1'b0;
    det.pos_x <= '0;
    det.pos_y <= '0;
    det.pix_x <= '0;
    det.pix_y <= '0;
    cfg.valid <= 1'b0;
    cfg.index <= '0;
    cfg.data  <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset settings: empty table, radius edge, bounds edges
    send_item(1'b0, 16'sd0, 16'sd0, 12'd0, 12'd0);
    send_item(1'b0, 16'sd1843, 16'sd0, 12'hfff, 12'hfff);
    send_item(1'b0, 16'sd1842, 16'sd0, 12'h123, 12'h456);
    send_item(1'b0, 16'sd22528, 16'sd0, any_pix(), any_pix());
    send_item(1'b0, 16'sd22527, 16'sd10239, any_pix(), any_pix());
    send_item(1'b0, -16'sd22528, 16'sd0, any_pix(), any_pix());
    send_item(1'b0, 16'sd0, -16'sd10240, any_pix(), any_pix());
    send_item(1'b0, 16'sh8000, 16'sh8000, any_pix(), any_pix());
    send_item(1'b0, 16'sd32767, 16'sd32767, any_pix(), any_pix());
    send_item(1'b1, -16'sd22527, -16'sd10239, 12'hfff, 12'hfff);
    send_item(1'b0, -16'sd22400, -16'sd10200, any_pix(), any_pix());
    // blacklist words skip the bounds check
    send_item(1'b1, 16'sd32767, 16'sh8000, 12'd0, 12'd0);
    send_item(1'b0, 16'sd22527, 16'sd10000, any_pix(), any_pix());
    // zero radius: an exact repeat is still new
    apply_settings(0, RST_X_LIMIT, RST_Y_LIMIT, 2);
    send_item(1'b0, 16'sd22527, 16'sd10239, any_pix(), any_pix());
    // widest radius lands on the tracked entry
    apply_settings(32767, RST_X_LIMIT, RST_Y_LIMIT, 0);
    send_item(1'b0, 16'sd20000, 16'sd5000, any_pix(), any_pix());

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: apply_settings(0, 32767, 32767, 0);
        1: apply_settings(32767, RST_X_LIMIT, RST_Y_LIMIT, 15);
        2: apply_settings(RST_MATCH_RADIUS, 0, 0, 16);
        3: apply_settings(3000, 32767, 32767, 31);
        default: apply_settings($urandom_range(200, 4000), $urandom_range(8000, 32767),
                                $urandom_range(8000, 32767), $urandom_range(0, 16));
      endcase
      repeat ((p == 2) ? 30 : 140) random_item();
    end

    wait_quiet();
    repeat (50) @(posedge clk);
    if (errors == 0)
      $display("tb_top passed");
    else
      $display("tb_top failed");
    $finish;
  end

endmodule
